// ----- hdl/sorted_table_binary_search_defines.svh -----
// assertion macros for the sorted table search block
// no dependencies; taken in by the modules that check their own logic
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/stbs_pkg.sv -----
// shared types and constants of the sorted table search block
// no dependencies
package stbs_pkg;

    localparam int KEY_W    = 32;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic rd_en;
        logic step;
        logic hit;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic key_eq;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/stbs_ctrl.sv -----
// search sequencer: accepts items and steps the datapath through the probes
// depends on stbs_pkg
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_action,
    output logic    o_s_tready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (i_status.empty) begin
                    n_state = ST_PUSH;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (i_status.key_eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_PUSH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_PROBE;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/stbs_dp.sv -----
// key table, search bounds, compare and result register
// depends on stbs_pkg and sorted_table_binary_search_defines.svh
`include "sorted_table_binary_search_defines.svh"
module stbs_dp
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [CNT_W-1:0]    i_cfg_data,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [KEY_W-1:0]    i_key_value,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic                o_found,
    output logic [IDX_W-1:0]    o_match_index
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW  = AW + 1;
    localparam int IW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int CWW = (NW > CNT_W) ? NW : CNT_W;
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_data;
    logic [CNT_W-1:0] r_count;
    logic signed [KEY_W-1:0] r_key;
    logic [NW-1:0]    r_lo;
    logic [NW-1:0]    r_hix;
    logic             r_found;
    logic [AW-1:0]    r_match;
    logic             r_out_valid;
    logic             r_out_found;
    logic [IDX_W-1:0] r_out_index;

    logic [IW:0]      wr_idx_ext;
    logic             wr_in_range;
    logic [CWW-1:0]   count_ext;
    logic [NW-1:0]    n_sat;
    logic [NW:0]      mid_sum;
    logic [AW-1:0]    mid;
    logic             key_lt;

    assign wr_idx_ext  = (IW + 1)'(i_entry_index);
    assign wr_in_range = wr_idx_ext < (IW + 1)'(TABLE_DEPTH);
    assign count_ext   = CWW'(r_count);
    assign n_sat       = (count_ext > CWW'(TABLE_DEPTH)) ? DEPTH_N : NW'(count_ext);
    assign mid_sum     = (NW + 1)'(r_lo) + (NW + 1)'(r_hix) - (NW + 1)'(1);
    assign mid         = mid_sum[AW:1];
    assign key_lt      = r_key < $signed(r_rd_data);

    assign o_status.empty    = r_lo >= r_hix;
    assign o_status.key_eq   = r_key == $signed(r_rd_data);
    assign o_status.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[wr_idx_ext[AW-1:0]] <= i_key_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= $signed(i_key_value);
            r_lo    <= '0;
            r_hix   <= n_sat;
            r_found <= 1'b0;
            r_match <= '0;
        end else if (i_cmd.step) begin
            if (key_lt) begin
                r_hix <= NW'(mid);
            end else begin
                r_lo  <= NW'(mid) + NW'(1);
            end
        end else if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_match <= mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_found <= r_found;
            r_out_index <= IDX_W'(r_match);
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_index = r_out_index;

    `STBS_ASSERT_NOW(a_probe_in_bounds, i_clk, i_rst_n, i_cmd.rd_en, r_lo < r_hix)
    `STBS_ASSERT_NOW(a_probe_below_count, i_clk, i_rst_n, i_cmd.rd_en, NW'(mid) < r_hix)
    `STBS_ASSERT_NOW(a_hit_is_equal, i_clk, i_rst_n, i_cmd.hit, o_status.key_eq)
    `STBS_ASSERT_NEXT(a_push_shows_result, i_clk, i_rst_n, i_cmd.push, r_out_valid)

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// top level of the sorted table search block
// depends on stbs_pkg, stbs_ctrl and stbs_dp
// A write transfer stores a signed 32-bit key at entry_index and gives no result. A search
// transfer runs a midpoint-first binary search over entries 0 to entry_count-1 (ascending
// signed order, count capped at TABLE_DEPTH) and gives one result transfer: found in tuser
// and match_index in tdata, 0 when not found. Each probe is a registered read of the key
// memory and then the compare, at most floor(log2(count)) + 1 probes; a search that misses
// ends on a final bounds check. The result waits while the previous result is still held
// on the output, and no new transfer is accepted until that result is pushed.
// The table is not cleared at reset; only written entries may be searched.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data,     // entry_count
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,      // entry_index, key_value, zero pad
    input  logic                i_s_tuser,      // action
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,      // match_index, zero pad
    output logic                o_m_tuser       // found
);

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] match_index;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_s_tdata[IDX_W-1:0]),
        .i_key_value   (i_s_tdata[IDX_W+KEY_W-1:IDX_W]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_found       (o_m_tuser),
        .o_match_index (match_index)
    );

    assign o_m_tdata = M_DATA_W'(match_index);

endmodule

// ----- tb/tb_sorted_table_binary_search.sv -----
// self-checking testbench for sorted_table_binary_search: directed table, then random phases
// of sorted table fills and searches, checked against a behavioural search predictor
// depends on stbs_pkg and the sorted_table_binary_search rtl
module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 1024;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SMALL_FILL    = 32;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_search_result;

    typedef struct packed {
        logic [S_DATA_W-KEY_W-IDX_W-1:0] pad;
        logic [KEY_W-1:0]                key;
        logic [IDX_W-1:0]                idx;
    } t_s_word;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_WRITE,
        ROW_SEARCH
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
        logic                    typed;
        logic                    found;
        logic [IDX_W-1:0]        match;
    } t_plan_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic                i_s_tuser   = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tuser;

    logic signed [KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [CNT_W-1:0]        live_count = '0;
    t_search_result          pending_results [$];
    int                      mismatches  = 0;
    int                      cycle_count = 0;
    int                      sink_wait   = 3;
    bit                      no_idle_src  = 1'b0;
    bit                      no_idle_sink = 1'b0;

    t_plan_row directed_plan [26] = '{
        '{ROW_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b1, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd1023, KEY_MIN,  11'd0, 1'b1, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd0,    KEY_MIN,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd1,    -32'sd1,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd2,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd3,    32'sd1,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd4,    KEY_MAX,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_CONFIG, 10'd0,    32'sd0,   11'd5, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    KEY_MIN,  11'd0, 1'b1, 1'b1, 10'd0},
        '{ROW_SEARCH, 10'd0,    KEY_MAX,  11'd0, 1'b1, 1'b1, 10'd4},
        '{ROW_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b1, 1'b1, 10'd2},
        '{ROW_SEARCH, 10'd0,    32'sd2,   11'd0, 1'b1, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    -32'sd2,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    32'sd1,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd1023, 32'sd5,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd3,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_CONFIG, 10'd0,    32'sd0,   11'd4, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_WRITE,  10'd1,    KEY_MAX,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    -32'sd1,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    KEY_MAX,  11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_CONFIG, 10'd0,    32'sd0,   11'd1, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    KEY_MIN,  11'd0, 1'b1, 1'b1, 10'd0},
        '{ROW_CONFIG, 10'd0,    32'sd0,   11'd0, 1'b0, 1'b0, 10'd0},
        '{ROW_SEARCH, 10'd0,    KEY_MIN,  11'd0, 1'b1, 1'b0, 10'd0}
    };

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("tb_sorted_table_binary_search: FAIL");
            $finish;
        end
    end

    function automatic t_search_result predict_search(input logic signed [KEY_W-1:0] key);
        int             lo;
        int             hi;
        int             mid;
        t_search_result res;
        res = '0;
        lo = 0;
        hi = ((live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count)) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < key_store[mid]) begin
                hi = mid - 1;
            end else if (key > key_store[mid]) begin
                lo = mid + 1;
            end else begin
                res.found = 1'b1;
                res.idx = IDX_W'(mid);
                lo = hi + 1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic check_result(input logic found, input logic [M_DATA_W-1:0] word);
        t_search_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result found=%b index=%0d with none pending",
                                      found, word[IDX_W-1:0]));
        end else begin
            want = pending_results.pop_front();
            if (found !== want.found) begin
                report_mismatch($sformatf("found %b, want %b", found, want.found));
            end
            if (word[IDX_W-1:0] !== want.idx) begin
                report_mismatch($sformatf("match_index %0d, want %0d",
                                          word[IDX_W-1:0], want.idx));
            end
            if (word[M_DATA_W-1:IDX_W] !== '0) begin
                report_mismatch($sformatf("tdata padding %h not zero", word[M_DATA_W-1:IDX_W]));
            end
        end
    endtask

    // result side: random stall after each transfer, checked against the oldest expectation
    always @(posedge i_clk) begin : result_sink
        int stall;
        if (i_rst_n) begin
            if (i_m_tready && o_m_tvalid) begin
                check_result(o_m_tuser, o_m_tdata);
                stall = no_idle_sink ? 0 : $urandom_range(0, MAX_GAP);
                if (stall != 0) begin
                    i_m_tready <= 1'b0;
                    sink_wait = stall;
                end
            end else if (!i_m_tready) begin
                if (sink_wait <= 1) begin
                    i_m_tready <= 1'b1;
                end
                sink_wait = sink_wait - 1;
            end
        end
    end

    task automatic transfer_item(input logic act, input logic [IDX_W-1:0] idx,
                                 input logic signed [KEY_W-1:0] key,
                                 input logic typed, input t_search_result typed_res);
        int gap;
        gap = no_idle_src ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= t_s_word'{'0, key, idx};
        i_s_tuser  <= act;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        if (act == ACT_WRITE) begin
            key_store[idx] = key;
        end else begin
            pending_results.push_back(typed ? typed_res : predict_search(key));
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [CNT_W-1:0] value);
        drain_results();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        live_count = value;
    endtask

    initial begin
        int                      random_sent;
        int                      phase_items;
        int                      n_live;
        int                      n_fill;
        int                      pick;
        int                      j;
        bit                      first_phase;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] key;
        longint                  upper;
        longint                  span_lo;
        longint unsigned         r64;
        longint                  fill_keys [$];

        foreach (key_store[k]) key_store[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r]) begin
            case (directed_plan[r].kind)
                ROW_CONFIG: begin
                    set_entry_count(directed_plan[r].count);
                end
                ROW_WRITE: begin
                    transfer_item(ACT_WRITE, directed_plan[r].idx, directed_plan[r].key,
                                  1'b0, '0);
                end
                default: begin
                    transfer_item(ACT_SEARCH, directed_plan[r].idx, directed_plan[r].key,
                                  directed_plan[r].typed,
                                  '{directed_plan[r].found, directed_plan[r].match});
                end
            endcase
        end

        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            // first phase fills the whole table, later ones mostly use a few entries
            pick = $urandom_range(0, 19);
            if (first_phase || pick == 0) begin
                count = CNT_W'(TABLE_DEPTH);
            end else if (pick == 1) begin
                count = '1;
            end else if (pick == 2) begin
                count = CNT_W'($urandom_range(TABLE_DEPTH + 1, 2047));
            end else if (pick == 3) begin
                count = CNT_W'($urandom_range(SMALL_FILL + 1, TABLE_DEPTH - 1));
            end else if (pick == 4) begin
                count = '0;
            end else begin
                count = CNT_W'($urandom_range(1, SMALL_FILL));
            end
            set_entry_count(count);
            no_idle_src  = ($urandom_range(0, 3) == 0);
            no_idle_sink = ($urandom_range(0, 3) == 0);
            n_live = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

            // sorted refill that stays at or below the entry after the last one in use
            n_fill = (first_phase || n_live <= SMALL_FILL) ? n_live : 0;
            if (n_fill != 0) begin
                upper = (n_fill < TABLE_DEPTH) ? longint'(key_store[n_fill]) : longint'(KEY_MAX);
                span_lo = ($urandom_range(0, 2) == 0) ? upper - $urandom_range(0, 40)
                                                     : longint'(KEY_MIN);
                if (span_lo < longint'(KEY_MIN)) begin
                    span_lo = KEY_MIN;
                end
                fill_keys.delete();
                for (int i = 0; i < n_fill; i++) begin
                    r64 = {$urandom, $urandom};
                    fill_keys.push_back(span_lo + longint'(r64 % (upper - span_lo + 1)));
                end
                fill_keys.sort();
                for (int i = 1; i < n_fill; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        fill_keys[i] = fill_keys[i-1];
                    end
                end
                for (int i = 0; i < n_fill; i++) begin
                    transfer_item(ACT_WRITE, IDX_W'(i), KEY_W'(fill_keys[i]), 1'b0, '0);
                    random_sent++;
                end
            end
            first_phase = 1'b0;

            phase_items = $urandom_range(20, 60);
            for (int i = 0; i < phase_items; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    transfer_item(ACT_WRITE, IDX_W'($urandom), KEY_W'($urandom), 1'b0, '0);
                end else begin
                    j = (n_live == 0) ? 0 : $urandom_range(0, n_live - 1);
                    if (pick < 12) begin
                        key = ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
                    end else if (pick < 30 || n_live == 0) begin
                        key = KEY_W'($urandom);
                    end else if (pick < 50) begin
                        key = key_store[j] + (($urandom_range(0, 1) == 0) ? 1 : -1);
                    end else begin
                        key = key_store[j];
                    end
                    transfer_item(ACT_SEARCH, IDX_W'($urandom), key, 1'b0, '0);
                end
                random_sent++;
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("tb_sorted_table_binary_search: PASS");
        end else begin
            $display("tb_sorted_table_binary_search: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_ctrl.sv
hdl/stbs_dp.sv
hdl/sorted_table_binary_search.sv
tb/tb_sorted_table_binary_search.sv
